// ----- sv/pid_pkg.sv -----
package pid_pkg;

  localparam int VALUE_W = 32;
  localparam int FRAC_W = 16;
  localparam int GAIN_W = 8 + FRAC_W;
  localparam int STEP_W = 16;
  localparam int MAG_W = VALUE_W + 1;
  localparam int MCAND_W = GAIN_W + STEP_W;
  localparam int PROD_W = MCAND_W + MAG_W;
  localparam int CNT_W = 6;
  localparam logic [CNT_W-1:0] MAG_STEPS = CNT_W'(MAG_W);

  localparam logic [2:0] REG_SET_POINT = 3'd0;
  localparam logic [2:0] REG_PROP_GAIN = 3'd1;
  localparam logic [2:0] REG_INT_GAIN = 3'd2;
  localparam logic [2:0] REG_DERIV_GAIN = 3'd3;
  localparam logic [2:0] REG_OUTPUT_MIN = 3'd4;
  localparam logic [2:0] REG_OUTPUT_MAX = 3'd5;
  localparam logic [2:0] REG_FIXED_STEP = 3'd6;
  localparam logic [2:0] REG_REVERSE = 3'd7;

  localparam logic [1:0] CLAMP_NONE = 2'd0;
  localparam logic [1:0] CLAMP_MAX = 2'd1;
  localparam logic [1:0] CLAMP_MIN = 2'd2;

  localparam logic signed [VALUE_W-1:0] VMAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic signed [VALUE_W-1:0] VMIN = {1'b1, {(VALUE_W-1){1'b0}}};

  typedef struct packed {
    logic start;
    logic neg;
    logic half;
  } mul_ctrl_t;

  function automatic logic signed [VALUE_W-1:0] sat_val(input logic signed [VALUE_W+2:0] x);
    logic signed [VALUE_W+2:0] hi;
    logic signed [VALUE_W+2:0] lo;
    hi = {3'b000, VMAX};
    lo = {3'b111, VMIN};
    if (x > hi) sat_val = VMAX;
    else if (x < lo) sat_val = VMIN;
    else sat_val = x[VALUE_W-1:0];
  endfunction

endpackage

// ----- sv/pid_ser_mul.sv -----
module pid_ser_mul (
  input  logic                                clk,
  input  logic                                rst,
  input  pid_pkg::mul_ctrl_t                  ctrl,
  input  logic [pid_pkg::MCAND_W-1:0]         mcand,
  input  logic [pid_pkg::MAG_W-1:0]           mplier,
  output logic                                done,
  output logic signed [pid_pkg::VALUE_W-1:0]  result
);
  import pid_pkg::*;

  logic [PROD_W-1:0] acc;
  logic [MCAND_W-1:0] mcand_r;
  logic [CNT_W-1:0] cnt;
  logic busy;
  logic neg_r;
  logic half_r;
  logic [MCAND_W:0] sum;
  logic [PROD_W-FRAC_W-1:0] rr;
  logic over;
  logic [VALUE_W-1:0] mag;

  // one multiplier bit per cycle, lsb first, product shifts in from the top
  assign sum = {1'b0, acc[PROD_W-1:MAG_W]} + (acc[0] ? {1'b0, mcand_r} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        acc <= {{MCAND_W{1'b0}}, mplier};
        mcand_r <= mcand;
        neg_r <= ctrl.neg;
        half_r <= ctrl.half;
        cnt <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        acc <= {sum, acc[MAG_W-1:1]};
        cnt <= cnt + 1'b1;
        if (cnt == MAG_STEPS - 1'b1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    rr = half_r ? {1'b0, acc[PROD_W-1:FRAC_W+1]} : acc[PROD_W-1:FRAC_W];
    over = (|rr[PROD_W-FRAC_W-1:VALUE_W]) || (rr[VALUE_W-1] && (|rr[VALUE_W-2:0]));
    mag = over ? VMIN : rr[VALUE_W-1:0];
    if (neg_r) result = -mag;
    else if (mag[VALUE_W-1]) result = VMAX;
    else result = mag;
  end

  a_start_busy: assert property (@(posedge clk) disable iff (rst) ctrl.start |=> busy)
    else $error("multiplier did not start");
  a_no_restart: assert property (@(posedge clk) disable iff (rst) busy |-> !ctrl.start)
    else $error("multiplier restarted while busy");
  a_done_end: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("multiplier done while busy");

endmodule

// ----- sv/pid_controller_trapezoid_antiwindup_top.sv -----
// PID controller, derivative on measurement, trapezoidal integral and back-calculation
// anti-windup, signed Q16.16 values and unsigned Q8.16 gains. A word with sample_due clear
// goes straight to S_DONE and returns the last drive; a due word runs the steps below.
// One bit-serial shift-add multiplier does P, I and D in turn, and a bit-serial restoring
// divider forms the measurement rate alongside the P product. S_SUM_I then adds to the
// integral, S_SUM_O sums the output, S_CLAMP clamps it and back-calculates the integral,
// and S_DONE loads the output register. One word is in work at a time. A finished result
// waits in S_DONE until the output register is free, and the block takes no new word
// until that result has been loaded into the output register.
module pid_controller_trapezoid_antiwindup_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [2:0]                          cfg_index,
  input  logic [pid_pkg::VALUE_W-1:0]         cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [pid_pkg::VALUE_W-1:0]  measurement,
  input  logic [pid_pkg::STEP_W-1:0]          elapsed_ms,
  input  logic                                sample_due,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [pid_pkg::VALUE_W-1:0]  drive,
  output logic                                updated,
  output logic [1:0]                          clamp_state
);
  import pid_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_PSTART, S_MUL_P, S_MUL_I, S_MUL_D, S_SUM_I, S_SUM_O, S_CLAMP, S_DONE
  } state_t;

  state_t state;

  logic signed [VALUE_W-1:0] set_point, output_min, output_max;
  logic [GAIN_W-1:0] prop_gain, int_gain, deriv_gain;
  logic [STEP_W-1:0] fixed_step;
  logic reverse_acting;

  logic signed [VALUE_W-1:0] integ, prev_meas, prev_err, prev_drive;
  logic signed [VALUE_W-1:0] err_r, meas_r, p_r, i_r, d_r, o_r;
  logic signed [MAG_W-1:0] esum_r, diff_r;
  logic [STEP_W-1:0] dt_r;
  logic [MCAND_W-1:0] kidt_r;

  logic signed [VALUE_W-1:0] res_drive;
  logic res_upd;
  logic [1:0] res_cs;

  logic [STEP_W-1:0] drem;
  logic [MAG_W-1:0] dq;
  logic [CNT_W-1:0] dcnt;
  logic dbusy;
  logic [STEP_W:0] dtry;
  logic dfit;

  logic signed [MAG_W-1:0] err_w, diff_w, esum_w;
  logic signed [VALUE_W-1:0] err_sat;
  logic [STEP_W-1:0] dt_w;

  mul_ctrl_t mctrl;
  logic [MCAND_W-1:0] mcand;
  logic [MAG_W-1:0] mplier;
  logic mdone;
  logic signed [VALUE_W-1:0] mres;

  logic signed [VALUE_W+2:0] ext_o, ext_i;
  logic over_max, under_min;

  function automatic logic [MAG_W-1:0] mag_of(input logic signed [MAG_W-1:0] x);
    mag_of = x[MAG_W-1] ? MAG_W'(-x) : MAG_W'(x);
  endfunction

  function automatic logic signed [VALUE_W+2:0] ext3(input logic signed [VALUE_W-1:0] x);
    ext3 = {{3{x[VALUE_W-1]}}, x};
  endfunction

  assign in_ready = (state == S_IDLE);

  always_comb begin
    err_w = {set_point[VALUE_W-1], set_point} - {measurement[VALUE_W-1], measurement};
    diff_w = {prev_meas[VALUE_W-1], prev_meas} - {measurement[VALUE_W-1], measurement};
    if (err_w[MAG_W-1] != err_w[MAG_W-2]) err_sat = err_w[MAG_W-1] ? VMIN : VMAX;
    else err_sat = err_w[VALUE_W-1:0];
    esum_w = {prev_err[VALUE_W-1], prev_err} + {err_sat[VALUE_W-1], err_sat};
    dt_w = (fixed_step != '0) ? fixed_step : elapsed_ms;
    if (dt_w == '0) dt_w = STEP_W'(1);
  end

  // shared multiplier: a finished P or I product starts the next one
  always_comb begin
    mctrl.start = (state == S_PSTART) || ((state == S_MUL_P || state == S_MUL_I) && mdone);
    mctrl.neg = 1'b0;
    mctrl.half = 1'b0;
    mcand = '0;
    mplier = '0;
    case (state)
      S_PSTART: begin
        mcand = {{STEP_W{1'b0}}, prop_gain};
        mplier = mag_of({err_r[VALUE_W-1], err_r});
        mctrl.neg = err_r[VALUE_W-1] ^ reverse_acting;
      end
      S_MUL_P: begin
        mcand = kidt_r;
        mplier = mag_of(esum_r);
        mctrl.neg = esum_r[MAG_W-1] ^ reverse_acting;
        mctrl.half = 1'b1;
      end
      S_MUL_I: begin
        mcand = {{STEP_W{1'b0}}, deriv_gain};
        mplier = dq;
        mctrl.neg = diff_r[MAG_W-1] ^ reverse_acting;
      end
      default: ;
    endcase
  end

  pid_ser_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (mctrl),
    .mcand  (mcand),
    .mplier (mplier),
    .done   (mdone),
    .result (mres)
  );

  assign dtry = {drem, dq[MAG_W-1]};
  assign dfit = dtry >= {1'b0, dt_r};

  always_comb begin
    ext_i = ext3(integ);
    ext_o = ext3(p_r) + ext3(integ) + ext3(d_r);
    over_max = o_r > output_max;
    under_min = o_r < output_min;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      dbusy <= 1'b0;
      dcnt <= '0;
      set_point <= '0;
      prop_gain <= '0;
      int_gain <= '0;
      deriv_gain <= '0;
      output_min <= VMIN;
      output_max <= VMAX;
      fixed_step <= '0;
      reverse_acting <= 1'b0;
      integ <= '0;
      prev_meas <= '0;
      prev_err <= '0;
      prev_drive <= '0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;

      if (cfg_we) begin
        case (cfg_index)
          REG_SET_POINT: set_point <= cfg_data;
          REG_PROP_GAIN: prop_gain <= cfg_data[GAIN_W-1:0];
          REG_INT_GAIN: int_gain <= cfg_data[GAIN_W-1:0];
          REG_DERIV_GAIN: deriv_gain <= cfg_data[GAIN_W-1:0];
          REG_OUTPUT_MIN: begin
            output_min <= cfg_data;
            if (integ < $signed(cfg_data)) integ <= cfg_data;
            else if (integ > output_max) integ <= output_max;
          end
          REG_OUTPUT_MAX: begin
            output_max <= cfg_data;
            if (integ < output_min) integ <= output_min;
            else if (integ > $signed(cfg_data)) integ <= cfg_data;
          end
          REG_FIXED_STEP: fixed_step <= cfg_data[STEP_W-1:0];
          REG_REVERSE: reverse_acting <= cfg_data[0];
          default: ;
        endcase
      end

      // restoring divider, one quotient bit per cycle
      if (state == S_PSTART) begin
        dq <= mag_of(diff_r);
        drem <= '0;
        dcnt <= '0;
        dbusy <= 1'b1;
      end else if (dbusy) begin
        drem <= dfit ? STEP_W'(dtry - {1'b0, dt_r}) : dtry[STEP_W-1:0];
        dq <= {dq[MAG_W-2:0], dfit};
        dcnt <= dcnt + 1'b1;
        if (dcnt == MAG_STEPS - 1'b1) dbusy <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (sample_due) begin
              meas_r <= measurement;
              err_r <= err_sat;
              esum_r <= esum_w;
              diff_r <= diff_w;
              dt_r <= dt_w;
              kidt_r <= int_gain * dt_w;
              state <= S_PSTART;
            end else begin
              res_drive <= prev_drive;
              res_upd <= 1'b0;
              res_cs <= CLAMP_NONE;
              state <= S_DONE;
            end
          end
        end
        S_PSTART: state <= S_MUL_P;
        S_MUL_P: begin
          if (mdone) begin
            p_r <= mres;
            state <= S_MUL_I;
          end
        end
        S_MUL_I: begin
          if (mdone) begin
            i_r <= mres;
            state <= S_MUL_D;
          end
        end
        S_MUL_D: begin
          if (mdone) begin
            d_r <= mres;
            state <= S_SUM_I;
          end
        end
        S_SUM_I: begin
          integ <= sat_val(ext_i + ext3(i_r));
          state <= S_SUM_O;
        end
        S_SUM_O: begin
          o_r <= sat_val(ext_o);
          state <= S_CLAMP;
        end
        S_CLAMP: begin
          if (over_max) begin
            integ <= sat_val(ext_i - (ext3(o_r) - ext3(output_max)));
            res_drive <= output_max;
            prev_drive <= output_max;
            res_cs <= CLAMP_MAX;
          end else if (under_min) begin
            integ <= sat_val(ext_i + (ext3(output_min) - ext3(o_r)));
            res_drive <= output_min;
            prev_drive <= output_min;
            res_cs <= CLAMP_MIN;
          end else begin
            res_drive <= o_r;
            prev_drive <= o_r;
            res_cs <= CLAMP_NONE;
          end
          res_upd <= 1'b1;
          prev_meas <= meas_r;
          prev_err <= err_r;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            drive <= res_drive;
            updated <= res_upd;
            clamp_state <= res_cs;
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_div_ready: assert property (@(posedge clk) disable iff (rst)
      (state == S_MUL_I && mdone) |-> !dbusy)
    else $error("rate quotient not ready for derivative product");
  a_hold_cs: assert property (@(posedge clk) disable iff (rst)
      (out_valid && !updated) |-> (clamp_state == CLAMP_NONE))
    else $error("repeated drive flagged as clamped");
  a_cs_code: assert property (@(posedge clk) disable iff (rst)
      out_valid |-> (clamp_state == CLAMP_NONE || clamp_state == CLAMP_MAX
                     || clamp_state == CLAMP_MIN))
    else $error("bad clamp code");
  a_max_drive: assert property (@(posedge clk) disable iff (rst)
      (out_valid && updated && clamp_state == CLAMP_MAX) |-> (drive == output_max))
    else $error("clamped drive differs from limit");

endmodule
